>>> sv/zxr_pkg.sv
// Shared types, constants and configuration register indexes for the cell renderer.
package zxr_pkg;

    // Frame geometry in lines and 8-pixel cells
    localparam int TOTAL_LINES       = 288;
    localparam int TOP_BORDER_LINES  = 48;
    localparam int SCREEN_LINES      = 192;
    localparam int TOTAL_CELLS       = 40;
    localparam int LEFT_BORDER_CELLS = 4;
    localparam int SCREEN_CELLS      = 32;

    // Field widths
    localparam int LINE_W   = 9;
    localparam int COLUMN_W = 6;
    localparam int ADDR_W   = 16;
    localparam int PIXELS_W = 32;
    localparam int NUM_PIX  = 8;
    localparam int COLOUR_W = 3;
    localparam int INDEX_W  = 4;
    localparam int FRAME_W  = 16;
    localparam int REFRESH_W = 7;

    // Screen window bounds at field width
    localparam logic [LINE_W-1:0] LINE_LIMIT   = LINE_W'(TOTAL_LINES);
    localparam logic [LINE_W-1:0] SCREEN_TOP   = LINE_W'(TOP_BORDER_LINES);
    localparam logic [LINE_W-1:0] SCREEN_BOT   = LINE_W'(TOP_BORDER_LINES + SCREEN_LINES);
    localparam logic [COLUMN_W-1:0] COL_LIMIT  = COLUMN_W'(TOTAL_CELLS);
    localparam logic [COLUMN_W-1:0] SCREEN_LEFT = COLUMN_W'(LEFT_BORDER_CELLS);
    localparam logic [COLUMN_W-1:0] SCREEN_RIGHT =
        COLUMN_W'(LEFT_BORDER_CELLS + SCREEN_CELLS);

    // Memory map
    localparam logic [ADDR_W-1:0] BITMAP_BASE = 16'h4000;
    localparam logic [ADDR_W-1:0] ATTR_BASE   = 16'h5800;
    localparam logic [ADDR_W-1:0] SNOW_KEEP   = 16'hFF80;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_BORDER_COLOUR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SNOW_ENABLE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_MASK    = 2'd2;
    localparam logic [FRAME_W-1:0]     FLASH_MASK_RESET  = 16'd16;

    // Input cell request
    typedef struct packed {
        logic [LINE_W-1:0]    line;
        logic [COLUMN_W-1:0]  cell_column;
        logic [7:0]           bitmap_byte;
        logic [7:0]           attr_byte;
        logic [FRAME_W-1:0]   frame_num;
        logic [REFRESH_W-1:0] refresh_value;
    } cell_t;

    // Rendered result request
    typedef struct packed {
        logic              is_border;
        logic [ADDR_W-1:0] bitmap_addr;
        logic [ADDR_W-1:0] attr_addr;
        logic [PIXELS_W-1:0] pixels;
    } result_t;

    // Live configuration
    typedef struct packed {
        logic [COLOUR_W-1:0] border_colour;
        logic                snow_enable;
        logic [FRAME_W-1:0]  flash_mask;
    } cfg_t;

endpackage

>>> sv/zxr_ifs.sv
// Handshake channel interfaces: cell input, rendered result and configuration writes.
interface zxr_cell_if;
    logic                            valid;
    logic                            ready;
    logic [zxr_pkg::LINE_W-1:0]      line;
    logic [zxr_pkg::COLUMN_W-1:0]    cell_column;
    logic [7:0]                      bitmap_byte;
    logic [7:0]                      attr_byte;
    logic [zxr_pkg::FRAME_W-1:0]     frame_num;
    logic [zxr_pkg::REFRESH_W-1:0]   refresh_value;

    modport source (output valid, line, cell_column, bitmap_byte, attr_byte,
                    frame_num, refresh_value, input ready);
    modport sink   (input valid, line, cell_column, bitmap_byte, attr_byte,
                    frame_num, refresh_value, output ready);
endinterface

interface zxr_result_if;
    logic                           valid;
    logic                           ready;
    logic                           is_border;
    logic [zxr_pkg::ADDR_W-1:0]     bitmap_addr;
    logic [zxr_pkg::ADDR_W-1:0]     attr_addr;
    logic [zxr_pkg::PIXELS_W-1:0]   pixels;

    modport source (output valid, is_border, bitmap_addr, attr_addr, pixels,
                    input ready);
    modport sink   (input valid, is_border, bitmap_addr, attr_addr, pixels,
                    output ready);
endinterface

interface zxr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [zxr_pkg::CFG_INDEX_W-1:0]   index;
    logic [zxr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/zxr_cfg_regs.sv
// Configuration register file: border colour, snow enable and flash mask.
module zxr_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [zxr_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [zxr_pkg::CFG_DATA_W-1:0]  wr_data,
    output zxr_pkg::cfg_t                 cfg
);

    zxr_pkg::cfg_t cfg_reg;
    zxr_pkg::cfg_t cfg_next;

    // Decode one register write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                zxr_pkg::CFG_BORDER_COLOUR:
                    cfg_next.border_colour = wr_data[zxr_pkg::COLOUR_W-1:0];
                zxr_pkg::CFG_SNOW_ENABLE:
                    cfg_next.snow_enable = wr_data[0];
                zxr_pkg::CFG_FLASH_MASK:
                    cfg_next.flash_mask = wr_data[zxr_pkg::FRAME_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.border_colour <= '0;
            cfg_reg.snow_enable   <= 1'b0;
            cfg_reg.flash_mask    <= zxr_pkg::FLASH_MASK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/zxr_render.sv
// Cell render logic: border test, bitmap/attribute addresses and colour indices.
module zxr_render (
    input  zxr_pkg::cell_t   item,
    input  zxr_pkg::cfg_t    cfg,
    output zxr_pkg::result_t res
);

    logic       screen;
    logic [7:0] sy;
    logic [4:0] cx;
    logic [zxr_pkg::LINE_W-1:0]   sy_full;
    logic [zxr_pkg::COLUMN_W-1:0] cx_full;
    logic [zxr_pkg::ADDR_W-1:0]   baddr;
    logic [zxr_pkg::ADDR_W-1:0]   aaddr;
    logic [zxr_pkg::INDEX_W-1:0]  ink;
    logic [zxr_pkg::INDEX_W-1:0]  paper;
    logic [zxr_pkg::INDEX_W-1:0]  ink_sw;
    logic [zxr_pkg::INDEX_W-1:0]  paper_sw;
    logic                         flash_on;
    logic [zxr_pkg::PIXELS_W-1:0] scr_pixels;
    logic [zxr_pkg::PIXELS_W-1:0] brd_pixels;

    // Screen window test
    assign screen = (item.line < zxr_pkg::LINE_LIMIT) &&
                    (item.cell_column < zxr_pkg::COL_LIMIT) &&
                    (item.line >= zxr_pkg::SCREEN_TOP) &&
                    (item.line < zxr_pkg::SCREEN_BOT) &&
                    (item.cell_column >= zxr_pkg::SCREEN_LEFT) &&
                    (item.cell_column < zxr_pkg::SCREEN_RIGHT);

    // Screen-relative coordinates, only meaningful inside the window
    assign sy_full = item.line - zxr_pkg::SCREEN_TOP;
    assign cx_full = item.cell_column - zxr_pkg::SCREEN_LEFT;
    assign sy = sy_full[7:0];
    assign cx = cx_full[4:0];

    // Interleaved bitmap line order and linear attribute rows, optional snow
    always_comb
    begin
        baddr = zxr_pkg::BITMAP_BASE | {3'b000, sy[7:6], sy[2:0], sy[5:3], cx};
        aaddr = zxr_pkg::ATTR_BASE + {6'b000000, sy[7:3], cx};
        if (cfg.snow_enable)
        begin
            baddr = (baddr & zxr_pkg::SNOW_KEEP) | {9'd0, item.refresh_value};
            aaddr = (aaddr & zxr_pkg::SNOW_KEEP) | {9'd0, item.refresh_value};
        end
    end

    // Ink and paper with bright, swapped in the flash phase
    assign ink      = {item.attr_byte[6], item.attr_byte[2:0]};
    assign paper    = {item.attr_byte[6], item.attr_byte[5:3]};
    assign flash_on = item.attr_byte[7] && (|(item.frame_num & cfg.flash_mask));
    assign ink_sw   = flash_on ? paper : ink;
    assign paper_sw = flash_on ? ink : paper;

    // One nibble per pixel, leftmost pixel in the top nibble
    always_comb
    begin
        for (int i = 0; i < zxr_pkg::NUM_PIX; i++)
        begin
            scr_pixels[i*zxr_pkg::INDEX_W +: zxr_pkg::INDEX_W] =
                item.bitmap_byte[i] ? ink_sw : paper_sw;
            brd_pixels[i*zxr_pkg::INDEX_W +: zxr_pkg::INDEX_W] =
                {1'b0, cfg.border_colour};
        end
    end

    // Result select
    always_comb
    begin
        if (screen)
        begin
            res.is_border   = 1'b0;
            res.bitmap_addr = baddr;
            res.attr_addr   = aaddr;
            res.pixels      = scr_pixels;
        end
        else
        begin
            res.is_border   = 1'b1;
            res.bitmap_addr = '0;
            res.attr_addr   = '0;
            res.pixels      = brd_pixels;
        end
    end

endmodule

>>> sv/zx_screen_cell_renderer.sv
// Spectrum-style screen cell renderer: one 8-pixel cell in, addresses and colour indices out.
// Takes one cell request per clock unless a held result stalls the stage, and returns one
// result request per cell, in order. An accepted cell is registered in the input register
// and its result in the result register, which offers it, with the addressing and colour
// logic between the two.
// A result left waiting holds in the result register while the next cell is still taken
// into the input register. Configuration is written through the cfg channel (index 0
// border colour, 1 snow enable, 2 flash mask), always ready; write it only while idle.
// Border cells return zero addresses and the border colour, without bright, in every pixel.
module zx_screen_cell_renderer (
    input  logic         clk,
    input  logic         rst_n,
    zxr_cell_if.sink     cells,
    zxr_result_if.source results,
    zxr_cfg_if.sink      cfg
);

    zxr_pkg::cfg_t    cfg_live;
    zxr_pkg::cell_t   cell_in;
    zxr_pkg::cell_t   cell_reg;
    zxr_pkg::result_t res_comb;
    zxr_pkg::result_t result_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             advance;
    logic             in_take;

    // Configuration registers
    assign cfg.ready = 1'b1;

    zxr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_live)
    );

    // Flow control: stage moves when the result register is empty or being drained
    assign advance      = !out_valid_reg || results.ready;
    assign cells.ready  = !in_valid_reg || advance;
    assign in_take      = cells.valid && cells.ready;
    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    assign cell_in.line          = cells.line;
    assign cell_in.cell_column   = cells.cell_column;
    assign cell_in.bitmap_byte   = cells.bitmap_byte;
    assign cell_in.attr_byte     = cells.attr_byte;
    assign cell_in.frame_num     = cells.frame_num;
    assign cell_in.refresh_value = cells.refresh_value;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cell_reg <= cell_in;
        end
        if (advance && in_valid_reg)
        begin
            result_reg <= res_comb;
        end
    end

    // Render logic between the two registers
    zxr_render u_render (
        .item (cell_reg),
        .cfg  (cfg_live),
        .res  (res_comb)
    );

    assign results.valid       = out_valid_reg;
    assign results.is_border   = result_reg.is_border;
    assign results.bitmap_addr = result_reg.bitmap_addr;
    assign results.attr_addr   = result_reg.attr_addr;
    assign results.pixels      = result_reg.pixels;

endmodule

>>> sv/zxr_checker.sv
// Port-level checks for the cell renderer, bound to the top level.
module zxr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        is_border,
    input logic [15:0] bitmap_addr,
    input logic [15:0] attr_addr,
    input logic [31:0] pixels
);

    // No result request right after reset release
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bitmap_addr) &&
            $stable(attr_addr) && $stable(pixels) && $stable(is_border))
        else $error("stalled result changed");

    // Input back-pressure only while a result is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with free result side");

    // Border results: zero addresses, one colour in all pixels without bright
    a_border: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_border |-> bitmap_addr == 16'h0000 && attr_addr == 16'h0000 &&
            pixels[31:4] == pixels[27:0] && !pixels[3])
        else $error("bad border result");

    // Screen results fall in the bitmap and attribute areas
    a_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_border |-> bitmap_addr[15:13] == 3'b010 &&
            attr_addr[15:10] == 6'b010110)
        else $error("screen address out of area");

endmodule

bind zx_screen_cell_renderer zxr_checker u_zxr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cells.valid),
    .in_ready    (cells.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .is_border   (results.is_border),
    .bitmap_addr (results.bitmap_addr),
    .attr_addr   (results.attr_addr),
    .pixels      (results.pixels)
);

>>> tb/zx_screen_cell_renderer_test.sv
// Self-checking testbench for zx_screen_cell_renderer: directed and random cells with a predictor.
`timescale 1ns / 100ps

module zx_screen_cell_renderer_test;

    // Register index outside the list; the block must ignore writes to it
    localparam logic [zxr_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RANDOM_HALF = 40;
    localparam int PHASES      = 6;

    logic clk;
    logic rst_n;

    zxr_cell_if   cell_ch ();
    zxr_result_if result_ch ();
    zxr_cfg_if    cfg_ch ();

    zx_screen_cell_renderer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cells   (cell_ch),
        .results (result_ch),
        .cfg     (cfg_ch)
    );

    // Testbench copy of the configuration registers
    logic [zxr_pkg::COLOUR_W-1:0] border_shade = '0;
    logic                         snow_on      = 1'b0;
    logic [zxr_pkg::FRAME_W-1:0]  flash_sel    = zxr_pkg::FLASH_MASK_RESET;

    zxr_pkg::cell_t   cell_queue[$];
    zxr_pkg::result_t render_queue[$];
    int unsigned cells_queued  = 0;
    int unsigned results_seen  = 0;
    int unsigned fail_count    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          cell_fire     = 1'b0;

    // Coverage tallies for the summary
    int unsigned screen_cells = 0;
    int unsigned border_cells = 0;
    int unsigned outside_cells = 0;
    int unsigned flash_swaps  = 0;
    int unsigned snow_cells   = 0;
    int unsigned cfg_writes   = 0;

    // Clock, 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Expected result of one cell under the current register copy
    function automatic zxr_pkg::result_t render_cell(zxr_pkg::cell_t c);
        zxr_pkg::result_t             r;
        logic [7:0]                   sy;
        logic [4:0]                   cx;
        logic [zxr_pkg::INDEX_W-1:0]  ink;
        logic [zxr_pkg::INDEX_W-1:0]  paper;
        logic [zxr_pkg::INDEX_W-1:0]  hold;
        r = '0;
        if (c.line < zxr_pkg::TOP_BORDER_LINES ||
            c.line >= zxr_pkg::TOP_BORDER_LINES + zxr_pkg::SCREEN_LINES ||
            c.cell_column < zxr_pkg::LEFT_BORDER_CELLS ||
            c.cell_column >= zxr_pkg::LEFT_BORDER_CELLS + zxr_pkg::SCREEN_CELLS)
        begin
            r.is_border = 1'b1;
            r.pixels    = {zxr_pkg::NUM_PIX{1'b0, border_shade}};
            return r;
        end
        sy = 8'(c.line - zxr_pkg::LINE_W'(zxr_pkg::TOP_BORDER_LINES));
        cx = 5'(c.cell_column - zxr_pkg::COLUMN_W'(zxr_pkg::LEFT_BORDER_CELLS));
        // Interleaved line order: third, pixel row, character row
        r.bitmap_addr = zxr_pkg::BITMAP_BASE | {3'b000, sy[7:6], sy[2:0], sy[5:3], cx};
        r.attr_addr   = zxr_pkg::ATTR_BASE + {6'b000000, sy[7:3], cx};
        if (snow_on)
        begin
            r.bitmap_addr = (r.bitmap_addr & zxr_pkg::SNOW_KEEP) | {9'b0, c.refresh_value};
            r.attr_addr   = (r.attr_addr & zxr_pkg::SNOW_KEEP) | {9'b0, c.refresh_value};
        end
        ink   = {c.attr_byte[6], c.attr_byte[2:0]};
        paper = {c.attr_byte[6], c.attr_byte[5:3]};
        // Flash phase swaps ink and paper
        if (c.attr_byte[7] && (c.frame_num & flash_sel) != '0)
        begin
            hold  = ink;
            ink   = paper;
            paper = hold;
        end
        for (int b = 0; b < zxr_pkg::NUM_PIX; b++)
            r.pixels[zxr_pkg::INDEX_W*b +: zxr_pkg::INDEX_W] = c.bitmap_byte[b] ? ink : paper;
        return r;
    endfunction

    function automatic zxr_pkg::cell_t make_cell(int ln, int col, int bits, int attr,
                                                 int frames, int refresh);
        zxr_pkg::cell_t c;
        c.line          = zxr_pkg::LINE_W'(ln);
        c.cell_column   = zxr_pkg::COLUMN_W'(col);
        c.bitmap_byte   = 8'(bits);
        c.attr_byte     = 8'(attr);
        c.frame_num     = zxr_pkg::FRAME_W'(frames);
        c.refresh_value = zxr_pkg::REFRESH_W'(refresh);
        return c;
    endfunction

    // Mostly screen cells, some in-frame border, some beyond the frame
    function automatic zxr_pkg::cell_t random_cell();
        zxr_pkg::cell_t c;
        int unsigned    pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            c.line        = zxr_pkg::LINE_W'($urandom_range(zxr_pkg::TOP_BORDER_LINES,
                                zxr_pkg::TOP_BORDER_LINES + zxr_pkg::SCREEN_LINES - 1));
            c.cell_column = zxr_pkg::COLUMN_W'($urandom_range(zxr_pkg::LEFT_BORDER_CELLS,
                                zxr_pkg::LEFT_BORDER_CELLS + zxr_pkg::SCREEN_CELLS - 1));
        end
        else if (pick < 88)
        begin
            c.line        = zxr_pkg::LINE_W'($urandom_range(zxr_pkg::TOTAL_LINES - 1));
            c.cell_column = zxr_pkg::COLUMN_W'($urandom_range(zxr_pkg::TOTAL_CELLS - 1));
        end
        else
        begin
            c.line        = zxr_pkg::LINE_W'($urandom);
            c.cell_column = zxr_pkg::COLUMN_W'($urandom);
        end
        c.bitmap_byte   = 8'($urandom);
        c.attr_byte     = 8'($urandom);
        c.frame_num     = ($urandom_range(99) < 20) ? '0 : zxr_pkg::FRAME_W'($urandom);
        c.refresh_value = zxr_pkg::REFRESH_W'($urandom);
        return c;
    endfunction

    task automatic queue_cell(zxr_pkg::cell_t c);
        cell_queue.push_back(c);
        cells_queued++;
    endtask

    // Sender holds off until every expected result is back
    task automatic drain_cells();
        while (results_seen < cells_queued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(logic [zxr_pkg::CFG_INDEX_W-1:0] idx,
                             logic [zxr_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Upper data bits are junk; only the register width must take effect
    task automatic set_config(logic [zxr_pkg::COLOUR_W-1:0] shade, logic snow,
                              logic [zxr_pkg::FRAME_W-1:0] mask);
        cfg_write(zxr_pkg::CFG_BORDER_COLOUR, {13'($urandom), shade});
        cfg_write(zxr_pkg::CFG_SNOW_ENABLE, {15'($urandom), snow});
        cfg_write(zxr_pkg::CFG_FLASH_MASK, mask);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        fail_count++;
        $display("mismatch at result %0d, %s: got %h, want %h",
                 results_seen, what, got, want);
    endtask

    // Cell request driver
    always @(negedge clk)
    begin : drive_cells
        zxr_pkg::cell_t pending;
        if (rst_n && (!cell_ch.valid || cell_fire))
        begin
            if (cell_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pending = cell_queue.pop_front();
                cell_ch.valid         <= 1'b1;
                cell_ch.line          <= pending.line;
                cell_ch.cell_column   <= pending.cell_column;
                cell_ch.bitmap_byte   <= pending.bitmap_byte;
                cell_ch.attr_byte     <= pending.attr_byte;
                cell_ch.frame_num     <= pending.frame_num;
                cell_ch.refresh_value <= pending.refresh_value;
            end
            else
                cell_ch.valid <= 1'b0;
        end
        cell_fire = 1'b0;
    end

    // Result back-pressure
    always @(negedge clk)
    begin
        result_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Register copy, prediction and result checking
    always @(posedge clk)
    begin : observe
        zxr_pkg::cell_t   taken;
        zxr_pkg::result_t got;
        zxr_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                cfg_writes++;
                case (cfg_ch.index)
                    zxr_pkg::CFG_BORDER_COLOUR:
                        border_shade = cfg_ch.data[zxr_pkg::COLOUR_W-1:0];
                    zxr_pkg::CFG_SNOW_ENABLE:
                        snow_on      = cfg_ch.data[0];
                    zxr_pkg::CFG_FLASH_MASK:
                        flash_sel    = cfg_ch.data;
                    default: ;
                endcase
            end

            if (cell_ch.valid && cell_ch.ready)
            begin
                taken.line          = cell_ch.line;
                taken.cell_column   = cell_ch.cell_column;
                taken.bitmap_byte   = cell_ch.bitmap_byte;
                taken.attr_byte     = cell_ch.attr_byte;
                taken.frame_num     = cell_ch.frame_num;
                taken.refresh_value = cell_ch.refresh_value;
                want = render_cell(taken);
                render_queue.push_back(want);
                cell_fire = 1'b1;
                if (want.is_border)
                begin
                    border_cells++;
                    if (taken.line >= zxr_pkg::TOTAL_LINES ||
                        taken.cell_column >= zxr_pkg::TOTAL_CELLS)
                        outside_cells++;
                end
                else
                begin
                    screen_cells++;
                    if (snow_on)
                        snow_cells++;
                    if (taken.attr_byte[7] && (taken.frame_num & flash_sel) != '0)
                        flash_swaps++;
                end
            end

            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                got.is_border   = result_ch.is_border;
                got.bitmap_addr = result_ch.bitmap_addr;
                got.attr_addr   = result_ch.attr_addr;
                got.pixels      = result_ch.pixels;
                if (render_queue.size() == 0)
                    report_mismatch("unexpected result", got.pixels, '0);
                else
                begin
                    want = render_queue.pop_front();
                    if (got.is_border !== want.is_border)
                        report_mismatch("is_border", 32'(got.is_border),
                                        32'(want.is_border));
                    if (got.bitmap_addr !== want.bitmap_addr)
                        report_mismatch("bitmap_addr", 32'(got.bitmap_addr),
                                        32'(want.bitmap_addr));
                    if (got.attr_addr !== want.attr_addr)
                        report_mismatch("attr_addr", 32'(got.attr_addr),
                                        32'(want.attr_addr));
                    if (got.pixels !== want.pixels)
                        report_mismatch("pixels", got.pixels, want.pixels);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("zx_screen_cell_renderer regression: fail");
        $finish;
    end

    // Stimulus sequence
    initial
    begin : stimulus
        rst_n                 = 1'b0;
        cell_ch.valid         = 1'b0;
        cell_ch.line          = '0;
        cell_ch.cell_column   = '0;
        cell_ch.bitmap_byte   = '0;
        cell_ch.attr_byte     = '0;
        cell_ch.frame_num     = '0;
        cell_ch.refresh_value = '0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = '0;
        cfg_ch.data           = '0;
        send_idle_pct         = 10;
        recv_idle_pct         = 81;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed cells under reset configuration (flash mask 16)
        queue_cell(make_cell(0, 0, 'hFF, 'hFF, 'hFFFF, 'h7F));    // top-left border
        queue_cell(make_cell(47, 20, 'h55, 'hC3, 'h0010, 'h11));   // last top border line
        queue_cell(make_cell(48, 4, 'h00, 'h00, 'h0000, 'h00));    // first screen cell
        queue_cell(make_cell(48, 35, 'hFF, 'h7F, 'h0000, 'h7F));   // last column, bright
        queue_cell(make_cell(239, 35, 'hA5, 'hC7, 'h0010, 'h55));  // flash swapped
        queue_cell(make_cell(239, 4, 'h3C, 'h87, 'hFFEF, 'h00));   // flash bit, phase off
        queue_cell(make_cell(240, 10, 'hFF, 'hFF, 'hFFFF, 'h7F));  // first bottom border
        queue_cell(make_cell(287, 39, 'h81, 'h42, 'h1234, 'h2A));  // last in-frame cell
        queue_cell(make_cell(288, 10, 'h81, 'h42, 'h1234, 'h2A));  // line beyond frame
        queue_cell(make_cell(511, 63, 'hFF, 'hFF, 'hFFFF, 'h7F));  // every field at max
        queue_cell(make_cell(100, 3, 'h0F, 'h38, 'h0000, 'h01));   // left border
        queue_cell(make_cell(100, 36, 'h0F, 'h38, 'h0000, 'h01));  // right border
        queue_cell(make_cell(100, 40, 'h0F, 'h38, 'h0000, 'h01));  // column beyond frame
        queue_cell(make_cell(200, 0, 'hF0, 'h07, 'h0000, 'h00));   // column zero
        queue_cell(make_cell(150, 63, 'hF0, 'h07, 'h0000, 'h00));  // column at max
        queue_cell(make_cell(55, 17, 'h5A, 'h38, 'h0000, 'h3C));   // interleave, first third
        queue_cell(make_cell(112, 20, 'h81, 'h4E, 'h0020, 'h40));  // second third
        queue_cell(make_cell(176, 30, 'hC3, 'hB1, 'h0030, 'h7F));  // third third, flash
        drain_cells();

        // Random phases over a spread of register settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 2)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 81;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (phase)
                0: set_config(3'd7, 1'b1, 16'hFFFF);
                1: set_config(3'd0, 1'b0, 16'h0000);
                2: set_config(3'd5, 1'b1, 16'h0001);
                3:
                begin
                    set_config(3'd3, 1'b0, 16'h8000);
                    cfg_write(CFG_UNUSED, 16'hFFFF);
                end
                4: set_config(3'd2, 1'b1, 16'h0010);
                default: set_config(3'd6, 1'b0, 16'h5A5A);
            endcase
            repeat (RANDOM_HALF) queue_cell(random_cell());
            drain_cells();
            repeat (RANDOM_HALF) queue_cell(random_cell());
            drain_cells();
        end

        repeat (8) @(negedge clk);
        if (render_queue.size() != 0)
            report_mismatch("results never returned", 32'(render_queue.size()), '0);

        $display("covered %0d cells: %0d screen (%0d flash swaps, %0d with snow), %0d border",
                 cells_queued, screen_cells, flash_swaps, snow_cells, border_cells);
        $display("%0d border cells lay beyond the frame; %0d register writes over %0d settings",
                 outside_cells, cfg_writes, PHASES + 1);
        if (fail_count == 0)
            $display("zx_screen_cell_renderer regression: pass");
        else
            $display("zx_screen_cell_renderer regression: fail");
        $finish;
    end

endmodule
